[design/cpc_pkg.sv]
// Shared types, codes and constants of the circle placement cost block.
package cpc_pkg;

    localparam int DEF_MAX_CIRCLES = 256;
    localparam int DEF_COORD_BITS  = 16;

    localparam int OPC_W      = 2;
    localparam int COORD_W    = 16;
    localparam int RAD_W      = 15;
    localparam int COST_W     = 26;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [COST_W-1:0] COST_MAX     = 26'd67108863;
    localparam logic [COST_W-1:0] COLLIDE_COST = 26'd1280000;

    localparam logic [COORD_W-1:0] RST_BOX_LEFT   = 16'd0;
    localparam logic [COORD_W-1:0] RST_BOX_RIGHT  = 16'd65535;
    localparam logic [COORD_W-1:0] RST_BOX_BOTTOM = 16'd0;
    localparam logic [COORD_W-1:0] RST_BOX_TOP    = 16'd65535;
    localparam logic [RAD_W-1:0]   RST_RADIUS     = 15'd1;

    typedef enum logic [OPC_W-1:0] {
        OP_CLEAR = 2'd0,
        OP_ADD   = 2'd1,
        OP_EVAL  = 2'd2,
        OP_NOP   = 2'd3
    } t_opcode;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_BOX_LEFT      = 3'd0,
        CFG_BOX_RIGHT     = 3'd1,
        CFG_BOX_BOTTOM    = 3'd2,
        CFG_BOX_TOP       = 3'd3,
        CFG_TESTED_RADIUS = 3'd4
    } t_cfg_addr;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MAP,
        S_SCAN,
        S_COST,
        S_DONE
    } t_state;

    typedef enum logic [2:0] {
        C_IDLE,
        C_SQR,
        C_SUM,
        C_ROOT,
        C_ROUND
    } t_cost_state;

    // Requests from the sequencer to the circle table
    typedef struct packed {
        logic clr;
        logic add;
        logic scan;
    } t_tbl_req;

    // Status of the circle table
    typedef struct packed {
        logic full;
        logic done;
        logic hit;
    } t_tbl_sts;

endpackage

[design/cpc_item_if.sv]
// Input item channel: opcode, circle for add and candidate position.
interface cpc_item_if;
    logic                          valid;
    logic                          ready;
    logic [cpc_pkg::OPC_W-1:0]     opcode;
    logic [cpc_pkg::COORD_W-1:0]   circle_x;
    logic [cpc_pkg::COORD_W-1:0]   circle_y;
    logic [cpc_pkg::RAD_W-1:0]     circle_radius;
    logic [cpc_pkg::COORD_W-1:0]   pos_x;
    logic [cpc_pkg::COORD_W-1:0]   pos_y;

    modport source (
        output valid, opcode, circle_x, circle_y, circle_radius, pos_x, pos_y,
        input  ready
    );
    modport sink (
        input  valid, opcode, circle_x, circle_y, circle_radius, pos_x, pos_y,
        output ready
    );
endinterface

[design/cpc_result_if.sv]
// Result channel: collision flag, cost, mapped center and status.
interface cpc_result_if;
    logic                          valid;
    logic                          ready;
    logic                          collided;
    logic [cpc_pkg::COST_W-1:0]    cost;
    logic [cpc_pkg::COORD_W-1:0]   center_x;
    logic [cpc_pkg::COORD_W-1:0]   center_y;
    logic                          solution_found;
    logic                          status;

    modport source (
        output valid, collided, cost, center_x, center_y, solution_found, status,
        input  ready
    );
    modport sink (
        input  valid, collided, cost, center_x, center_y, solution_found, status,
        output ready
    );
endinterface

[design/cpc_cfg_if.sv]
// Configuration write channel: register address and write data.
interface cpc_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [cpc_pkg::CFG_ADDR_W-1:0] addr;
    logic [cpc_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, addr, data, input ready);
    modport sink   (input valid, addr, data, output ready);
endinterface

[design/cpc_map.sv]
// Maps a Q0.16 candidate position to a pixel center in the shrunk box, saturated to the coordinate range.
module cpc_map #(
    parameter int COORD_BITS = cpc_pkg::DEF_COORD_BITS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [cpc_pkg::COORD_W-1:0]   i_pos_x,
    input  logic [cpc_pkg::COORD_W-1:0]   i_pos_y,
    input  logic [cpc_pkg::COORD_W-1:0]   i_box_left,
    input  logic [cpc_pkg::COORD_W-1:0]   i_box_right,
    input  logic [cpc_pkg::COORD_W-1:0]   i_box_bottom,
    input  logic [cpc_pkg::COORD_W-1:0]   i_box_top,
    input  logic [cpc_pkg::RAD_W-1:0]     i_radius,
    output logic                          o_done,
    output logic [COORD_BITS-1:0]         o_x0,
    output logic [COORD_BITS-1:0]         o_y0
);
    import cpc_pkg::*;

    localparam int LW  = 19;                 // border and span width
    localparam int PW  = 36;                 // product width
    localparam int QW  = PW - 16;            // rounded quotient width
    localparam int CW  = 21;                 // unsaturated center width
    localparam int XW  = (COORD_BITS + 2 > CW) ? COORD_BITS + 2 : CW;
    localparam logic signed [XW-1:0] CMAX = XW'((64'd1 << COORD_BITS) - 64'd1);

    // lane 0 is x, lane 1 is y
    logic [COORD_W-1:0]        lo_src  [2];
    logic [COORD_W-1:0]        hi_src  [2];
    logic [COORD_W-1:0]        pos_src [2];
    logic signed [LW-1:0]      lo_a    [2];
    logic signed [LW-1:0]      hi_a    [2];
    logic signed [PW-1:0]      rnd     [2];
    logic signed [QW-1:0]      q       [2];
    logic signed [CW-1:0]      c       [2];
    logic signed [XW-1:0]      c_ext   [2];

    logic signed [LW-1:0]      r_lo    [2];
    logic signed [LW-1:0]      r_sp    [2];
    logic [COORD_W-1:0]        r_pos   [2];
    logic signed [PW-1:0]      r_pr    [2];
    logic [COORD_BITS-1:0]     r_c     [2];
    logic                      r_v1, r_v2, r_v3;

    assign lo_src[0]  = i_box_left;
    assign lo_src[1]  = i_box_bottom;
    assign hi_src[0]  = i_box_right;
    assign hi_src[1]  = i_box_top;
    assign pos_src[0] = i_pos_x;
    assign pos_src[1] = i_pos_y;

    always_comb begin
        for (int l = 0; l < 2; l++) begin
            lo_a[l]  = $signed({3'b0, lo_src[l]}) + $signed({4'b0, i_radius});
            hi_a[l]  = $signed({3'b0, hi_src[l]}) - $signed({4'b0, i_radius});
            rnd[l]   = r_pr[l] + $signed(PW'(32768));
            q[l]     = rnd[l][PW-1:16];
            c[l]     = CW'(r_lo[l]) + CW'(q[l]);
            c_ext[l] = XW'(c[l]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v1 <= i_start;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int l = 0; l < 2; l++) begin
            if (i_start) begin
                r_lo[l]  <= lo_a[l];
                r_sp[l]  <= hi_a[l] - lo_a[l];
                r_pos[l] <= pos_src[l];
            end
            if (r_v1) begin
                r_pr[l] <= $signed({1'b0, r_pos[l]}) * r_sp[l];
            end
            if (r_v2) begin
                // saturate the center into the coordinate range
                if (c_ext[l] < 0) begin
                    r_c[l] <= '0;
                end else if (c_ext[l] > CMAX) begin
                    r_c[l] <= COORD_BITS'(CMAX);
                end else begin
                    r_c[l] <= COORD_BITS'(c_ext[l]);
                end
            end
        end
    end

    assign o_done = r_v3;
    assign o_x0   = r_c[0];
    assign o_y0   = r_c[1];

endmodule

[design/cpc_scan.sv]
// Circle table memory with add, clear and a pipelined collision scan.
module cpc_scan #(
    parameter int MAX_CIRCLES = cpc_pkg::DEF_MAX_CIRCLES,
    parameter int COORD_BITS  = cpc_pkg::DEF_COORD_BITS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  cpc_pkg::t_tbl_req             i_req,
    input  logic [cpc_pkg::COORD_W-1:0]   i_circle_x,
    input  logic [cpc_pkg::COORD_W-1:0]   i_circle_y,
    input  logic [cpc_pkg::RAD_W-1:0]     i_circle_radius,
    input  logic [COORD_BITS-1:0]         i_x0,
    input  logic [COORD_BITS-1:0]         i_y0,
    input  logic [cpc_pkg::RAD_W-1:0]     i_radius,
    output cpc_pkg::t_tbl_sts             o_sts
);
    import cpc_pkg::*;

    localparam int AW  = (MAX_CIRCLES > 1) ? $clog2(MAX_CIRCLES) : 1;
    localparam int CW  = $clog2(MAX_CIRCLES + 1);
    localparam int SW  = (COORD_BITS < COORD_W) ? COORD_BITS : COORD_W;
    localparam int EW  = 2 * SW + RAD_W;
    localparam int XW  = (COORD_BITS > COORD_W) ? COORD_BITS : COORD_W;
    localparam int SDW = XW + 1;
    localparam int SQW = 2 * SDW;
    localparam int RSW = RAD_W + 1;

    logic [EW-1:0]            r_mem [MAX_CIRCLES];
    logic [EW-1:0]            r_rd;
    logic [CW-1:0]            r_count;
    logic [CW-1:0]            r_idx;
    logic                     r_busy, r_v1, r_v2, r_hit, r_done;
    logic [COORD_BITS-1:0]    r_x0, r_y0;
    logic [RAD_W-1:0]         r_rad;
    logic [SQW-1:0]           r_dx2, r_dy2;
    logic [2*RSW-1:0]         r_rs2;

    logic                     full, wr_en, rd_en, drained;
    logic [SW-1:0]            ex, ey;
    logic [RAD_W-1:0]         er;
    logic signed [SDW-1:0]    dx, dy;
    logic signed [SQW-1:0]    px, py;
    logic [RSW-1:0]           rs;
    logic [SQW:0]             d2;

    assign full    = (r_count == CW'(MAX_CIRCLES));
    assign wr_en   = i_req.add && !full;
    assign rd_en   = r_busy && (r_idx != r_count);
    assign drained = r_busy && !rd_en && !r_v1 && !r_v2;

    assign ex = r_rd[EW-1 -: SW];
    assign ey = r_rd[RAD_W +: SW];
    assign er = r_rd[RAD_W-1:0];
    assign dx = $signed({{(SDW-COORD_BITS){1'b0}}, r_x0}) - $signed({{(SDW-SW){1'b0}}, ex});
    assign dy = $signed({{(SDW-COORD_BITS){1'b0}}, r_y0}) - $signed({{(SDW-SW){1'b0}}, ey});
    assign px = dx * dx;
    assign py = dy * dy;
    assign rs = RSW'(r_rad) + RSW'(er);
    assign d2 = (SQW+1)'(r_dx2) + (SQW+1)'(r_dy2);

    // table storage: one write port for add, one read port for the scan
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_count[AW-1:0]] <= {i_circle_x[SW-1:0], i_circle_y[SW-1:0], i_circle_radius};
        end
        if (rd_en) begin
            r_rd <= r_mem[r_idx[AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_busy  <= 1'b0;
            r_idx   <= '0;
            r_v1    <= 1'b0;
            r_v2    <= 1'b0;
            r_hit   <= 1'b0;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            r_v1   <= rd_en;
            r_v2   <= r_v1;
            if (i_req.clr) begin
                r_count <= '0;
            end else if (wr_en) begin
                r_count <= r_count + 1'b1;
            end
            if (i_req.scan) begin
                r_busy <= 1'b1;
                r_idx  <= '0;
                r_hit  <= 1'b0;
            end else begin
                if (rd_en) begin
                    r_idx <= r_idx + 1'b1;
                end
                if (r_v2 && (d2 <= (SQW+1)'(r_rs2))) begin
                    r_hit <= 1'b1;
                end
                if (drained) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.scan) begin
            r_x0  <= i_x0;
            r_y0  <= i_y0;
            r_rad <= i_radius;
        end
        if (r_v1) begin
            r_dx2 <= $unsigned(px);
            r_dy2 <= $unsigned(py);
            r_rs2 <= rs * rs;
        end
    end

    assign o_sts.full = full;
    assign o_sts.done = r_done;
    assign o_sts.hit  = r_hit;

endmodule

[design/cpc_cost.sv]
// Distance cost to the box's bottom middle plus center y, with an iterative square root.
module cpc_cost #(
    parameter int COORD_BITS = cpc_pkg::DEF_COORD_BITS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [COORD_BITS-1:0]         i_x0,
    input  logic [COORD_BITS-1:0]         i_y0,
    input  logic [cpc_pkg::COORD_W-1:0]   i_box_left,
    input  logic [cpc_pkg::COORD_W-1:0]   i_box_right,
    input  logic [cpc_pkg::COORD_W-1:0]   i_box_bottom,
    output logic                          o_done,
    output logic [cpc_pkg::COST_W-1:0]    o_cost
);
    import cpc_pkg::*;

    localparam int XW   = (COORD_BITS > COORD_W) ? COORD_BITS : COORD_W;
    localparam int DW   = XW + 2;
    localparam int SQW  = 2 * DW;
    localparam int D2W  = (SQW + 1 > 41) ? SQW + 1 : 41;
    localparam int VW   = 57;
    localparam int SUMW = 34;
    localparam logic [D2W-1:0] D2_LIM  = D2W'(64'd1 << 40);
    localparam logic [VW-1:0]  BIT_TOP = VW'(64'd1 << 56);

    t_cost_state r_state, n_state;

    logic signed [DW-1:0]     r_dx, r_dy;
    logic [SQW-1:0]           r_dx2, r_dy2;
    logic                     r_sat, r_done;
    logic [VW-1:0]            r_rem, r_root, r_bit;
    logic [COORD_BITS-1:0]    r_y0;
    logic [COST_W-1:0]        r_cost;

    logic                     do_sqr, do_sum, do_root, do_round;
    logic [COORD_W:0]         xsum;
    logic [COORD_W-1:0]       xm;
    logic signed [SQW-1:0]    px, py;
    logic [D2W-1:0]           d2;
    logic [VW-1:0]            trial, s;
    logic [SUMW-1:0]          total;

    assign xsum  = {1'b0, i_box_left} + {1'b0, i_box_right};
    assign xm    = xsum[COORD_W:1];
    assign px    = r_dx * r_dx;
    assign py    = r_dy * r_dy;
    assign d2    = D2W'(r_dx2) + D2W'(r_dy2);
    assign trial = r_root + r_bit;
    assign s     = r_root + VW'(r_rem > r_root);
    assign total = SUMW'(s) + (SUMW'(r_y0) << 8);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            C_IDLE:  if (i_start) n_state = C_SQR;
            C_SQR:   n_state = C_SUM;
            C_SUM:   n_state = C_ROOT;
            C_ROOT:  if (r_bit[0]) n_state = C_ROUND;
            C_ROUND: n_state = C_IDLE;
            default: n_state = C_IDLE;
        endcase
    end

    always_comb begin
        do_sqr   = 1'b0;
        do_sum   = 1'b0;
        do_root  = 1'b0;
        do_round = 1'b0;
        unique case (r_state)
            C_SQR:   do_sqr   = 1'b1;
            C_SUM:   do_sum   = 1'b1;
            C_ROOT:  do_root  = 1'b1;
            C_ROUND: do_round = 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= C_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= do_round;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dx <= $signed({{(DW-COORD_BITS){1'b0}}, i_x0}) - $signed({{(DW-COORD_W){1'b0}}, xm});
            r_dy <= $signed({{(DW-COORD_BITS){1'b0}}, i_y0})
                  - $signed({{(DW-COORD_W){1'b0}}, i_box_bottom});
            r_y0 <= i_y0;
        end
        if (do_sqr) begin
            r_dx2 <= $unsigned(px);
            r_dy2 <= $unsigned(py);
        end
        if (do_sum) begin
            r_sat  <= (d2 > D2_LIM);
            r_rem  <= {d2[40:0], 16'b0};
            r_root <= '0;
            r_bit  <= BIT_TOP;
        end
        if (do_root) begin
            // one result bit per step
            if (r_rem >= trial) begin
                r_rem  <= r_rem - trial;
                r_root <= (r_root >> 1) + r_bit;
            end else begin
                r_root <= r_root >> 1;
            end
            r_bit <= r_bit >> 2;
        end
        if (do_round) begin
            if (r_sat || (total > SUMW'(COST_MAX))) begin
                r_cost <= COST_MAX;
            end else begin
                r_cost <= COST_W'(total);
            end
        end
    end

    assign o_done = r_done;
    assign o_cost = r_cost;

endmodule

[design/circle_placement_cost.sv]
// Top level of the circle placement cost block: sequencer, registers, result stage.
//
// Placement cost engine. Add transactions append a circle (x, y, radius) to an
// on-chip table of MAX_CIRCLES entries, a clear transaction empties it, and an
// evaluate transaction maps a Q0.16 candidate position into a pixel center
// between the box borders shrunk by tested_radius, checks it against every
// stored circle and returns either the collision sentinel or the distance to
// the box's bottom middle plus center y, in 1/256 pixel. One transaction is
// worked on at a time. Clear, add and the unused opcode go straight from
// acceptance to the result handoff. An evaluate runs position mapping, then a
// scan of the stored circles, one table read per cycle through the memory's
// single read port followed by a compare pipeline, and, when there is no
// collision, the distance and a 29-step square root, one result bit per step.
// A finished result waits in an output register, so the next transaction is
// taken while it is still pending. The table needs no clearing pass after
// reset; only entries below the fill count are ever read. Configuration may
// be written whenever no transaction is in flight.
module circle_placement_cost #(
    parameter int MAX_CIRCLES = cpc_pkg::DEF_MAX_CIRCLES,
    parameter int COORD_BITS  = cpc_pkg::DEF_COORD_BITS
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    cpc_item_if.sink     i_item,
    cpc_result_if.source o_result,
    cpc_cfg_if.sink      i_cfg
);
    import cpc_pkg::*;

    // configuration registers
    logic [COORD_W-1:0]    r_box_left, r_box_right, r_box_bottom, r_box_top;
    logic [RAD_W-1:0]      r_radius;

    t_state                r_state, n_state;
    logic                  r_found;

    // pending result, built while the transaction is worked on
    logic                  r_res_coll, r_res_status;
    logic [COST_W-1:0]     r_res_cost;
    logic [COORD_W-1:0]    r_res_cx, r_res_cy;

    // output register
    logic                  r_out_valid, r_out_coll, r_out_found, r_out_status;
    logic [COST_W-1:0]     r_out_cost;
    logic [COORD_W-1:0]    r_out_cx, r_out_cy;

    logic                  accept, out_free, out_load;
    logic                  map_start, map_done, cost_start, cost_done;
    t_opcode               op;
    t_tbl_req              tbl_req;
    t_tbl_sts              tbl_sts;
    logic [COORD_BITS-1:0] x0, y0;
    logic [COST_W-1:0]     cost_val;

    assign op       = t_opcode'(i_item.opcode);
    assign accept   = i_item.valid && i_item.ready;
    assign out_free = !r_out_valid || o_result.ready;

    // configuration writes are always taken
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_box_left   <= RST_BOX_LEFT;
            r_box_right  <= RST_BOX_RIGHT;
            r_box_bottom <= RST_BOX_BOTTOM;
            r_box_top    <= RST_BOX_TOP;
            r_radius     <= RST_RADIUS;
        end else if (i_cfg.valid) begin
            unique case (t_cfg_addr'(i_cfg.addr))
                CFG_BOX_LEFT:      r_box_left   <= i_cfg.data;
                CFG_BOX_RIGHT:     r_box_right  <= i_cfg.data;
                CFG_BOX_BOTTOM:    r_box_bottom <= i_cfg.data;
                CFG_BOX_TOP:       r_box_top    <= i_cfg.data;
                CFG_TESTED_RADIUS: r_radius     <= i_cfg.data[RAD_W-1:0];
                default: ;
            endcase
        end
    end

    // next state: evaluate walks through map, scan and, with no collision, cost;
    // all else goes straight to the result handoff
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = (op == OP_EVAL) ? S_MAP : S_DONE;
                end
            end
            S_MAP:  if (map_done) n_state = S_SCAN;
            S_SCAN: begin
                if (tbl_sts.done) begin
                    n_state = tbl_sts.hit ? S_DONE : S_COST;
                end
            end
            S_COST: if (cost_done) n_state = S_DONE;
            S_DONE: if (out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // control outputs decoded from the state
    always_comb begin
        i_item.ready = 1'b0;
        tbl_req      = '0;
        map_start    = 1'b0;
        cost_start   = 1'b0;
        out_load     = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                i_item.ready = 1'b1;
                tbl_req.clr  = i_item.valid && (op == OP_CLEAR);
                tbl_req.add  = i_item.valid && (op == OP_ADD);
                map_start    = i_item.valid && (op == OP_EVAL);
            end
            S_MAP:  tbl_req.scan = map_done;
            S_SCAN: cost_start   = tbl_sts.done && !tbl_sts.hit;
            S_DONE: out_load     = out_free;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_found <= 1'b0;
        end else begin
            r_state <= n_state;
            // clear drops the found flag, a collision-free evaluate sets it
            if (tbl_req.clr) begin
                r_found <= 1'b0;
            end else if (r_state == S_COST && cost_done) begin
                r_found <= 1'b1;
            end
        end
    end

    // build the pending result
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_res_coll   <= 1'b0;
            r_res_cost   <= '0;
            r_res_cx     <= '0;
            r_res_cy     <= '0;
            r_res_status <= (op == OP_ADD) && tbl_sts.full;
        end
        if (r_state == S_MAP && map_done) begin
            r_res_cx <= COORD_W'(x0);
            r_res_cy <= COORD_W'(y0);
        end
        if (r_state == S_SCAN && tbl_sts.done && tbl_sts.hit) begin
            r_res_coll <= 1'b1;
            r_res_cost <= COLLIDE_COST;
        end
        if (r_state == S_COST && cost_done) begin
            r_res_cost <= cost_val;
        end
    end

    // output register: hold until the sink takes the transaction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_coll   <= r_res_coll;
            r_out_cost   <= r_res_cost;
            r_out_cx     <= r_res_cx;
            r_out_cy     <= r_res_cy;
            r_out_found  <= r_found;
            r_out_status <= r_res_status;
        end
    end

    assign o_result.valid          = r_out_valid;
    assign o_result.collided       = r_out_coll;
    assign o_result.cost           = r_out_cost;
    assign o_result.center_x       = r_out_cx;
    assign o_result.center_y       = r_out_cy;
    assign o_result.solution_found = r_out_found;
    assign o_result.status         = r_out_status;

    cpc_map #(
        .COORD_BITS (COORD_BITS)
    ) u_map (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (map_start),
        .i_pos_x      (i_item.pos_x),
        .i_pos_y      (i_item.pos_y),
        .i_box_left   (r_box_left),
        .i_box_right  (r_box_right),
        .i_box_bottom (r_box_bottom),
        .i_box_top    (r_box_top),
        .i_radius     (r_radius),
        .o_done       (map_done),
        .o_x0         (x0),
        .o_y0         (y0)
    );

    cpc_scan #(
        .MAX_CIRCLES (MAX_CIRCLES),
        .COORD_BITS  (COORD_BITS)
    ) u_scan (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_req           (tbl_req),
        .i_circle_x      (i_item.circle_x),
        .i_circle_y      (i_item.circle_y),
        .i_circle_radius (i_item.circle_radius),
        .i_x0            (x0),
        .i_y0            (y0),
        .i_radius        (r_radius),
        .o_sts           (tbl_sts)
    );

    cpc_cost #(
        .COORD_BITS (COORD_BITS)
    ) u_cost (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (cost_start),
        .i_x0         (x0),
        .i_y0         (y0),
        .i_box_left   (r_box_left),
        .i_box_right  (r_box_right),
        .i_box_bottom (r_box_bottom),
        .o_done       (cost_done),
        .o_cost       (cost_val)
    );

endmodule

[tb/cpc_tb_pkg.sv]
// Testbench types and the placement cost scoreboard with its own model of the block.
`timescale 1ns / 100ps
package cpc_tb_pkg;
    import cpc_pkg::*;

    localparam int TABLE_DEPTH = DEF_MAX_CIRCLES;
    localparam longint COORD_LIMIT = (64'sd1 << DEF_COORD_BITS) - 1;
    localparam longint DIST_CAP = 64'sd1 << 40;
    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        t_opcode              opcode;
        logic [COORD_W-1:0]   circle_x;
        logic [COORD_W-1:0]   circle_y;
        logic [RAD_W-1:0]     circle_radius;
        logic [COORD_W-1:0]   pos_x;
        logic [COORD_W-1:0]   pos_y;
    } t_item;

    typedef struct packed {
        logic                 collided;
        logic [COST_W-1:0]    cost;
        logic [COORD_W-1:0]   center_x;
        logic [COORD_W-1:0]   center_y;
        logic                 solution_found;
        logic                 status;
    } t_outcome;

    class placement_scoreboard;
        logic [COORD_W-1:0] stored_x [TABLE_DEPTH];
        logic [COORD_W-1:0] stored_y [TABLE_DEPTH];
        logic [RAD_W-1:0]   stored_r [TABLE_DEPTH];
        int unsigned        fill;
        bit                 found;
        logic [COORD_W-1:0] box_left, box_right, box_bottom, box_top;
        logic [RAD_W-1:0]   radius;
        t_outcome           awaited_results[$];
        int unsigned        mismatches, results_seen, evaluations, collisions, refusals;

        function new();
            fill = 0;
            found = 1'b0;
            box_left = RST_BOX_LEFT;
            box_right = RST_BOX_RIGHT;
            box_bottom = RST_BOX_BOTTOM;
            box_top = RST_BOX_TOP;
            radius = RST_RADIUS;
            mismatches = 0;
            results_seen = 0;
            evaluations = 0;
            collisions = 0;
            refusals = 0;
        endfunction

        function void write_reg(logic [CFG_ADDR_W-1:0] addr, logic [CFG_DATA_W-1:0] data);
            case (addr)
                CFG_BOX_LEFT:      box_left = data;
                CFG_BOX_RIGHT:     box_right = data;
                CFG_BOX_BOTTOM:    box_bottom = data;
                CFG_BOX_TOP:       box_top = data;
                CFG_TESTED_RADIUS: radius = data[RAD_W-1:0];
                default: ;
            endcase
        endfunction

        // Scale a Q0.16 fraction onto [lo, hi] with round half up, then saturate.
        function longint map_center(logic [COORD_W-1:0] pos, longint lo, longint hi);
            longint p, c;
            p = pos;
            c = lo + ((p * (hi - lo) + 32768) >>> 16);
            if (c < 0) c = 0;
            if (c > COORD_LIMIT) c = COORD_LIMIT;
            return c;
        endfunction

        function longint unsigned int_sqrt(longint unsigned v);
            longint unsigned res, probe;
            res = 0;
            probe = 64'd1 << 62;
            while (probe > v) probe >>= 2;
            while (probe != 0) begin
                if (v >= res + probe) begin
                    v -= res + probe;
                    res = (res >> 1) + probe;
                end else begin
                    res >>= 1;
                end
                probe >>= 2;
            end
            return res;
        endfunction

        function void note_item(t_item it);
            t_outcome e;
            longint r, lft, rgt, btm, tp, x0, y0, dx, dy, xm, d2, reach, sx, sy, sr;
            longint unsigned v, s, yu, total;
            e = '0;
            case (it.opcode)
                OP_CLEAR: begin
                    fill = 0;
                    found = 1'b0;
                end
                OP_ADD: begin
                    if (fill >= TABLE_DEPTH) begin
                        e.status = 1'b1;
                        refusals++;
                    end else begin
                        stored_x[fill] = it.circle_x;
                        stored_y[fill] = it.circle_y;
                        stored_r[fill] = it.circle_radius;
                        fill++;
                    end
                end
                OP_EVAL: begin
                    evaluations++;
                    r = radius;
                    lft = box_left;
                    rgt = box_right;
                    btm = box_bottom;
                    tp = box_top;
                    x0 = map_center(it.pos_x, lft + r, rgt - r);
                    y0 = map_center(it.pos_y, btm + r, tp - r);
                    e.center_x = x0[COORD_W-1:0];
                    e.center_y = y0[COORD_W-1:0];
                    for (int i = 0; i < fill; i++) begin
                        sx = stored_x[i];
                        sy = stored_y[i];
                        sr = stored_r[i];
                        dx = x0 - sx;
                        dy = y0 - sy;
                        d2 = dx * dx + dy * dy;
                        reach = r + sr;
                        if (d2 <= reach * reach) begin
                            e.collided = 1'b1;
                            break;
                        end
                    end
                    if (e.collided) begin
                        e.cost = COLLIDE_COST;
                        collisions++;
                    end else begin
                        found = 1'b1;
                        xm = (lft + rgt) >>> 1;
                        dx = x0 - xm;
                        dy = y0 - btm;
                        d2 = dx * dx + dy * dy;
                        if (d2 > DIST_CAP) begin
                            e.cost = COST_MAX;
                        end else begin
                            v = d2;
                            v = v << 16;
                            s = int_sqrt(v);
                            if (v - s * s > s) s++;
                            yu = y0;
                            total = s + (yu << 8);
                            if (total > COST_MAX) total = COST_MAX;
                            e.cost = total[COST_W-1:0];
                        end
                    end
                end
                default: ;
            endcase
            e.solution_found = found;
            awaited_results.push_back(e);
        endfunction

        function void check_result(t_outcome got);
            t_outcome want;
            results_seen++;
            if (awaited_results.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("result %0d arrived with nothing awaited: collided=%0d cost=%0d",
                             results_seen, got.collided, got.cost);
                return;
            end
            want = awaited_results.pop_front();
            if (got !== want) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT) begin
                    $display("result %0d expected: collided=%0d cost=%0d center=(%0d,%0d) found=%0d status=%0d",
                             results_seen, want.collided, want.cost, want.center_x,
                             want.center_y, want.solution_found, want.status);
                    $display("result %0d actual:   collided=%0d cost=%0d center=(%0d,%0d) found=%0d status=%0d",
                             results_seen, got.collided, got.cost, got.center_x,
                             got.center_y, got.solution_found, got.status);
                end
            end
        endfunction

        function int unsigned outstanding();
            return awaited_results.size();
        endfunction
    endclass

endpackage

[tb/tb_top.sv]
// Top of the testbench: clock, reset, channel drivers, stimulus phases and final verdict.
`timescale 1ns / 100ps
module tb_top;
    import cpc_pkg::*;
    import cpc_tb_pkg::*;

    localparam int RESET_CYCLES  = 12;
    localparam int ITEM_BUDGET   = 1550;
    localparam int HOLD_CYCLES   = 400;
    localparam int SETTLE_CYCLES = 64;
    localparam int MAX_GAP       = 40;
    localparam int FILL_EPISODE  = 30;
    localparam int PRESS_EPISODE = 5;
    // Slowest legal run: every item an evaluate on a full table, each result
    // held by the longest receiver stall, each item behind the longest sender
    // gap. That stays well under this bound.
    localparam int CYCLE_LIMIT   = 2_000_000;
    // Index outside the register map: the write must have no effect.
    localparam logic [CFG_ADDR_W-1:0] CFG_UNUSED = 3'd5;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    cpc_item_if   item_ch ();
    cpc_result_if result_ch ();
    cpc_cfg_if    cfg_ch ();

    circle_placement_cost dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (item_ch),
        .o_result (result_ch),
        .i_cfg    (cfg_ch)
    );

    placement_scoreboard board = new();

    int unsigned sender_idle_pct = 0;
    int unsigned receiver_stall_pct = 0;
    int unsigned hold_req = 0;
    int unsigned items_sent = 0;
    int unsigned settings_applied = 0;
    int unsigned cycles = 0;

    always #5 i_clk = ~i_clk;

    // Watchdog: end the run if it hangs.
    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results still awaited",
                     cycles, board.outstanding());
            $display("circle_placement_cost: mismatch");
            $finish;
        end
    end

    // Result side: check every accepted transaction, then pick next cycle's ready.
    // A hold request from the stimulus forces a long stretch of ready low.
    initial begin : result_sink
        t_outcome    got;
        int unsigned hold_seen;
        int unsigned hold_left;
        hold_seen = 0;
        hold_left = 0;
        result_ch.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && result_ch.valid === 1'b1 && result_ch.ready === 1'b1) begin
                got.collided       = result_ch.collided;
                got.cost           = result_ch.cost;
                got.center_x       = result_ch.center_x;
                got.center_y       = result_ch.center_y;
                got.solution_found = result_ch.solution_found;
                got.status         = result_ch.status;
                board.check_result(got);
            end
            if (hold_req != hold_seen) begin
                hold_seen = hold_req;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left != 0) begin
                hold_left--;
                result_ch.ready <= 1'b0;
            end else begin
                result_ch.ready <= ($urandom_range(99) >= receiver_stall_pct);
            end
        end
    end

    function automatic t_item make_item(t_opcode op, logic [COORD_W-1:0] cx,
                                        logic [COORD_W-1:0] cy, logic [RAD_W-1:0] cr,
                                        logic [COORD_W-1:0] px, logic [COORD_W-1:0] py);
        t_item it;
        it.opcode = op;
        it.circle_x = cx;
        it.circle_y = cy;
        it.circle_radius = cr;
        it.pos_x = px;
        it.pos_y = py;
        return it;
    endfunction

    // Random payload everywhere; callers override what matters.
    function automatic t_item noise_item(t_opcode op);
        return make_item(op, $urandom, $urandom, $urandom, $urandom, $urandom);
    endfunction

    // Add a circle, mostly inside the current box and small next to it.
    function automatic t_item random_add();
        t_item       it;
        int unsigned x_lo, x_hi, y_lo, y_hi, lim;
        it = noise_item(OP_ADD);
        if ($urandom_range(4) != 0) begin
            x_lo = (board.box_left < board.box_right) ? board.box_left : board.box_right;
            x_hi = (board.box_left < board.box_right) ? board.box_right : board.box_left;
            y_lo = (board.box_bottom < board.box_top) ? board.box_bottom : board.box_top;
            y_hi = (board.box_bottom < board.box_top) ? board.box_top : board.box_bottom;
            lim = (x_hi - x_lo) / 8;
            if (lim > 32767) lim = 32767;
            it.circle_x = $urandom_range(x_hi, x_lo);
            it.circle_y = $urandom_range(y_hi, y_lo);
            it.circle_radius = $urandom_range(lim, 0);
        end
        return it;
    endfunction

    function automatic t_item random_eval();
        t_item it;
        it = noise_item(OP_EVAL);
        if ($urandom_range(6) == 0) begin
            case ($urandom_range(2))
                0: it.pos_x = 16'd0;
                1: it.pos_x = 16'hFFFF;
                default: it.pos_x = 16'h8000;
            endcase
            it.pos_y = $urandom_range(1) ? 16'hFFFF : 16'd0;
        end
        return it;
    endfunction

    // Offer one transaction after a random idle gap; hold it until accepted.
    task automatic send_item(t_item it);
        int unsigned gap;
        gap = 0;
        while (gap < MAX_GAP && $urandom_range(99) < sender_idle_pct) gap++;
        if (gap != 0) begin
            item_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        item_ch.valid         <= 1'b1;
        item_ch.opcode        <= it.opcode;
        item_ch.circle_x      <= it.circle_x;
        item_ch.circle_y      <= it.circle_y;
        item_ch.circle_radius <= it.circle_radius;
        item_ch.pos_x         <= it.pos_x;
        item_ch.pos_y         <= it.pos_y;
        do @(posedge i_clk); while (item_ch.ready !== 1'b1);
        board.note_item(it);
        if (it.opcode != OP_NOP) items_sent++;
    endtask

    // Drop valid and hold until every awaited result has come back.
    task automatic wait_drained();
        item_ch.valid <= 1'b0;
        while (board.outstanding() != 0) @(posedge i_clk);
    endtask

    // Leaves valid high so back-to-back writes need no extra edge.
    task automatic write_reg(logic [CFG_ADDR_W-1:0] addr, logic [CFG_DATA_W-1:0] data);
        cfg_ch.valid <= 1'b1;
        cfg_ch.addr  <= addr;
        cfg_ch.data  <= data;
        do @(posedge i_clk); while (cfg_ch.ready !== 1'b1);
        board.write_reg(addr, data);
    endtask

    task automatic program_box(logic [15:0] left, logic [15:0] right, logic [15:0] bottom,
                               logic [15:0] top, logic [15:0] radius_word);
        write_reg(CFG_BOX_LEFT, left);
        write_reg(CFG_BOX_RIGHT, right);
        write_reg(CFG_BOX_BOTTOM, bottom);
        write_reg(CFG_BOX_TOP, top);
        write_reg(CFG_TESTED_RADIUS, radius_word);
        cfg_ch.valid <= 1'b0;
        settings_applied++;
    endtask

    // Pick a new box: full range, raw random words, or an ordered box with a
    // radius that leaves room to move.
    task automatic random_box();
        int unsigned pick, a, b, span;
        logic [15:0] x_lo, x_hi, y_lo, y_hi, rad;
        pick = $urandom_range(9);
        if (pick == 0) begin
            x_lo = 16'd0;
            x_hi = 16'hFFFF;
            y_lo = 16'd0;
            y_hi = 16'hFFFF;
            rad = $urandom_range(100);
        end else if (pick == 1) begin
            x_lo = $urandom;
            x_hi = $urandom;
            y_lo = $urandom;
            y_hi = $urandom;
            rad = $urandom;
        end else begin
            a = $urandom_range(65535);
            b = $urandom_range(65535);
            x_lo = (a < b) ? a : b;
            x_hi = (a < b) ? b : a;
            a = $urandom_range(65535);
            b = $urandom_range(65535);
            y_lo = (a < b) ? a : b;
            y_hi = (a < b) ? b : a;
            span = (x_hi - x_lo < y_hi - y_lo) ? x_hi - x_lo : y_hi - y_lo;
            span = span / 4;
            if (span > 2000) span = 2000;
            rad = $urandom_range(span);
        end
        program_box(x_lo, x_hi, y_lo, y_hi, rad);
    endtask

    initial begin : stimulus
        int unsigned ep;
        int unsigned n;
        item_ch.valid = 1'b0;
        item_ch.opcode = OP_CLEAR;
        item_ch.circle_x = '0;
        item_ch.circle_y = '0;
        item_ch.circle_radius = '0;
        item_ch.pos_x = '0;
        item_ch.pos_y = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.addr = CFG_BOX_LEFT;
        cfg_ch.data = '0;

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part under the reset box: empty table, corners, unused
        // opcode, a touch exactly at the sum of the radii and a near miss.
        send_item(make_item(OP_EVAL, 0, 0, 0, 16'd0, 16'd0));
        send_item(make_item(OP_EVAL, 0, 0, 0, 16'hFFFF, 16'hFFFF));
        send_item(make_item(OP_NOP, 16'hFFFF, 16'hFFFF, 15'h7FFF, 16'hFFFF, 16'hFFFF));
        send_item(make_item(OP_ADD, 16'd4, 16'd5, 15'd4, 0, 0));
        send_item(make_item(OP_EVAL, 0, 0, 0, 16'd0, 16'd0));
        send_item(make_item(OP_CLEAR, 0, 0, 0, 0, 0));
        send_item(make_item(OP_ADD, 16'd4, 16'd6, 15'd4, 0, 0));
        send_item(make_item(OP_EVAL, 0, 0, 0, 16'd0, 16'd0));
        send_item(make_item(OP_ADD, 16'd0, 16'd0, 15'd0, 0, 0));
        send_item(make_item(OP_ADD, 16'hFFFF, 16'hFFFF, 15'h7FFF, 0, 0));
        send_item(make_item(OP_ADD, 16'h8000, 16'h8000, 15'd10, 0, 0));
        send_item(make_item(OP_EVAL, 0, 0, 0, 16'h8000, 16'h8000));
        send_item(make_item(OP_EVAL, 0, 0, 0, 16'hFFFF, 16'd0));
        send_item(make_item(OP_NOP, 0, 0, 0, 0, 0));
        send_item(make_item(OP_CLEAR, 0, 0, 0, 0, 0));
        wait_drained();

        // Crossed borders after shrinking, with the radius word's top bit set.
        program_box(16'd100, 16'd200, 16'hFFFF, 16'd0, 16'hFFFF);
        send_item(make_item(OP_EVAL, 0, 0, 0, 16'd0, 16'd0));
        send_item(make_item(OP_EVAL, 0, 0, 0, 16'hFFFF, 16'hFFFF));
        send_item(make_item(OP_EVAL, 0, 0, 0, 16'h8000, 16'd1));
        wait_drained();

        // Box pinned at the top: the borders shrunk from left and bottom lie past the coordinate range.
        write_reg(CFG_UNUSED, 16'hFFFF);
        program_box(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h7FFF);
        send_item(make_item(OP_EVAL, 0, 0, 0, 16'd0, 16'd0));
        wait_drained();

        // Zero box and zero radius: a point touching a point still collides.
        program_box(16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
        send_item(make_item(OP_EVAL, 0, 0, 0, 16'hFFFF, 16'hFFFF));
        send_item(make_item(OP_ADD, 16'd0, 16'd0, 15'd0, 0, 0));
        send_item(make_item(OP_EVAL, 0, 0, 0, 16'hFFFF, 16'hFFFF));
        wait_drained();

        // Random part: episodes of clear, adds and evaluates, with noise mixed in.
        ep = 0;
        while (items_sent < ITEM_BUDGET) begin
            case (ep % 4)
                0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
                1: begin sender_idle_pct = 73; receiver_stall_pct = 0;  end
                2: begin sender_idle_pct = 0;  receiver_stall_pct = 73; end
                default: begin sender_idle_pct = 23; receiver_stall_pct = 23; end
            endcase
            if (ep % 6 == 0) begin
                wait_drained();
                random_box();
            end
            if (ep == PRESS_EPISODE) begin
                // Hold the result side off while offering back to back, so the
                // output register fills and the input stalls.
                sender_idle_pct = 0;
                hold_req <= hold_req + 1;
                repeat (12) send_item($urandom_range(1) ? random_add() : random_eval());
            end
            if (ep == FILL_EPISODE) begin
                // Fill the table to the brim, overflow it, then scan it whole.
                send_item(noise_item(OP_CLEAR));
                repeat (TABLE_DEPTH + 3) send_item(random_add());
                repeat (4) send_item(random_eval());
            end else begin
                if ($urandom_range(9) != 0) send_item(noise_item(OP_CLEAR));
                n = $urandom_range(12);
                repeat (n) send_item(random_add());
                n = $urandom_range(8, 1);
                repeat (n) begin
                    if ($urandom_range(11) == 0)
                        send_item(noise_item(t_opcode'($urandom_range(3))));
                    else
                        send_item(random_eval());
                end
            end
            ep++;
        end

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("covered %0d transactions under %0d register settings: %0d evaluations,",
                 items_sent, settings_applied, board.evaluations);
        $display("  %0d of them collided, %0d adds refused on a full table, %0d results checked",
                 board.collisions, board.refusals, board.results_seen);
        if (board.mismatches == 0 && board.outstanding() == 0) begin
            $display("circle_placement_cost: match");
        end else begin
            $display("%0d mismatches, %0d results never arrived",
                     board.mismatches, board.outstanding());
            $display("circle_placement_cost: mismatch");
        end
        $finish;
    end

endmodule
